FILE: sv/wsu_pkg.sv
// ----------------------------------------------------------------------------
// wsu_pkg: shared types and constants of the 1-D wave stencil update
// sample and coefficient widths, stencil taps and datapath command bundle
// ----------------------------------------------------------------------------
package wsu_pkg;

  localparam int SAMPLE_W  = 18;
  localparam int KAPPA_W   = 16;
  localparam int STENCIL_R = 4;
  localparam int WIN_LEN   = 2 * STENCIL_R + 1;
  localparam int TAPS      = STENCIL_R + 1;
  localparam int TAP_IDX_W = $clog2(TAPS);
  localparam int FILL_W    = $clog2(WIN_LEN + 1);
  localparam int COEF_W    = 22;

  localparam logic [KAPPA_W-1:0] KAPPA_RESET = KAPPA_W'(30304);

  // datapath commands issued by the sequencer
  typedef struct packed {
    logic                 win_load;
    logic                 mac_en;
    logic [TAP_IDX_W-1:0] mac_sel;
    logic                 lo_en;
    logic                 hi_en;
    logic                 sum_en;
    logic                 rnd_en;
    logic                 out_load;
  } wsu_cmd_t;

  // stencil coefficients in Q.20, tap 0 applies to twice the centre
  function automatic logic signed [COEF_W-1:0] stencil_coef(input logic [TAP_IDX_W-1:0] d);
    logic signed [COEF_W-1:0] c;
    unique case (d)
      TAP_IDX_W'(0): c = -COEF_W'(1492764);
      TAP_IDX_W'(1): c =  COEF_W'(1677722);
      TAP_IDX_W'(2): c = -COEF_W'(209715);
      TAP_IDX_W'(3): c =  COEF_W'(26631);
      TAP_IDX_W'(4): c = -COEF_W'(1872);
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/wsu_if.sv
// ----------------------------------------------------------------------------
// wsu_in_if / wsu_out_if: valid-ready channels of the wave stencil update
// one transfer when valid and ready are both high at a rising clock edge
// ----------------------------------------------------------------------------
interface wsu_in_if import wsu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] older_centre;
  logic                       line_start;
  logic                       line_last;

  modport source (output valid, old_sample, older_centre, line_start, line_last,
                  input ready);
  modport sink   (input valid, old_sample, older_centre, line_start, line_last,
                  output ready);
endinterface

interface wsu_out_if import wsu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] new_value;
  logic                       last;

  modport source (output valid, new_value, last, input ready);
  modport sink   (input valid, new_value, last, output ready);
endinterface

FILE: sv/wsu_ctrl.sv
// ----------------------------------------------------------------------------
// wsu_ctrl: sequencer of the wave stencil update
// tracks window fill and steps the shared multiply-accumulate datapath
// ----------------------------------------------------------------------------
module wsu_ctrl import wsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_start_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wsu_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_SUM,
    ST_RND,
    ST_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [TAP_IDX_W-1:0] cnt_q, cnt_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    logic [FILL_W-1:0] fill_nx;
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    fill_nx     = fill_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.win_load = 1'b1;
          priority if (in_start_i) begin
            fill_nx = FILL_W'(1);
          end else if (fill_q < FILL_W'(WIN_LEN)) begin
            fill_nx = fill_q + FILL_W'(1);
          end
          fill_d = fill_nx;
          if (fill_nx == FILL_W'(WIN_LEN)) begin
            state_d = ST_MAC;
            cnt_d   = '0;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_sel = cnt_q;
        if (cnt_q == TAP_IDX_W'(TAPS - 1)) begin
          state_d = ST_SCL_LO;
        end else begin
          cnt_d = cnt_q + TAP_IDX_W'(1);
        end
      end
      ST_SCL_LO: begin
        cmd_o.lo_en = 1'b1;
        state_d     = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd_o.hi_en = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // output register free or emptying this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/wsu_dpath.sv
// ----------------------------------------------------------------------------
// wsu_dpath: datapath of the wave stencil update
// sample window, shared stencil mac, kappa scaling, rounding and saturation
// ----------------------------------------------------------------------------
module wsu_dpath import wsu_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [KAPPA_W-1:0]         cfg_wdata_i,
  input  wsu_cmd_t                   cmd_i,
  input  logic signed [SAMPLE_W-1:0] old_sample_i,
  input  logic signed [SAMPLE_W-1:0] older_centre_i,
  input  logic                       line_last_i,
  output logic signed [SAMPLE_W-1:0] new_value_o,
  output logic                       last_o
);

  localparam int PAIR_W = SAMPLE_W + 1;
  localparam int PROD_W = COEF_W + PAIR_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SL_W   = 24;
  localparam int SH_W   = ACC_W - SL_W;
  localparam int PLO_W  = KAPPA_W + SL_W;
  localparam int PHI_W  = KAPPA_W + 1 + SH_W;
  localparam int P_W    = PHI_W + SL_W;
  localparam int RND_SH = 36;
  localparam int R_W    = P_W - RND_SH;
  localparam int FIN_W  = R_W + 2;

  localparam logic signed [P_W-1:0]   RND_HALF = P_W'(1) <<< (RND_SH - 1);
  localparam logic signed [FIN_W-1:0] SAT_HI   = FIN_W'((1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [FIN_W-1:0] SAT_LO   = -SAT_HI - FIN_W'(1);

  logic [KAPPA_W-1:0]         kappa_q;
  logic signed [SAMPLE_W-1:0] win_q [WIN_LEN];
  logic signed [SAMPLE_W-1:0] older_q;
  logic                       last_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [PLO_W-1:0]           plo_q;
  logic signed [PHI_W-1:0]    phi_q;
  logic signed [P_W-1:0]      prod_q;
  logic signed [R_W-1:0]      r_q;
  logic signed [SAMPLE_W-1:0] new_value_q;
  logic                       last_out_q;

  logic signed [PAIR_W-1:0]   pair [TAPS];
  logic signed [PROD_W-1:0]   mac_prod;
  logic signed [ACC_W-1:0]    acc_d;
  logic [PLO_W-1:0]           plo_d;
  logic signed [PHI_W-1:0]    phi_d;
  logic signed [P_W-1:0]      prod_d;
  logic signed [P_W-1:0]      rsum;
  logic signed [FIN_W-1:0]    fin;
  logic signed [SAMPLE_W-1:0] sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kappa_q <= KAPPA_RESET;
    end else if (cfg_we_i) begin
      kappa_q <= cfg_wdata_i;
    end
  end

  // window shift and item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[WIN_LEN-1] <= old_sample_i;
      older_q          <= older_centre_i;
      last_q           <= line_last_i;
    end
  end

  // symmetric pair sums, tap 0 is twice the centre
  always_comb begin
    pair[0] = {win_q[STENCIL_R], 1'b0};
    for (int d = 1; d < TAPS; d++) begin
      pair[d] = PAIR_W'(win_q[STENCIL_R - d]) + PAIR_W'(win_q[STENCIL_R + d]);
    end
  end

  assign mac_prod = stencil_coef(cmd_i.mac_sel) * pair[cmd_i.mac_sel];
  assign acc_d    = (cmd_i.mac_sel == '0) ? ACC_W'(mac_prod) : acc_q + ACC_W'(mac_prod);

  // kappa times stencil sum in two partial products
  assign plo_d  = PLO_W'(kappa_q) * PLO_W'(acc_q[SL_W-1:0]);
  assign phi_d  = $signed(PHI_W'({1'b0, kappa_q})) * PHI_W'($signed(acc_q[ACC_W-1:SL_W]));
  assign prod_d = $signed({phi_q, {SL_W{1'b0}}}) + $signed(P_W'(plo_q));

  // round to nearest, ties away from zero
  assign rsum = prod_q + (prod_q[P_W-1] ? RND_HALF - P_W'(1) : RND_HALF);

  assign fin = FIN_W'(r_q) + (FIN_W'(win_q[STENCIL_R]) <<< 1) - FIN_W'(older_q);

  always_comb begin
    priority if (fin > SAT_HI) begin
      sat = SAT_HI[SAMPLE_W-1:0];
    end else if (fin < SAT_LO) begin
      sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat = fin[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.lo_en) begin
      plo_q <= plo_d;
    end
    if (cmd_i.hi_en) begin
      phi_q <= phi_d;
    end
    if (cmd_i.sum_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rnd_en) begin
      r_q <= rsum[P_W-1:RND_SH];
    end
    if (cmd_i.out_load) begin
      new_value_q <= sat;
      last_out_q  <= last_q;
    end
  end

  assign new_value_o = new_value_q;
  assign last_o      = last_out_q;

endmodule

FILE: sv/wave_1d_stencil_update.sv
// ----------------------------------------------------------------------------
// wave_1d_stencil_update: 1-D leapfrog wave update, 8th-order 9-point stencil
// streams previous-level samples into a window and returns updated values
// ----------------------------------------------------------------------------
// A sample that does not yet complete the 9-sample window leaves the block
// idle and ready; a sample that completes it occupies the block through the
// transfer, five stencil multiply-accumulate steps on the one shared
// multiplier, two kappa partial products, sum, rounding and output load.
// The result sits in an output register, so the next sample is taken while
// it waits; a later result holds at output load, and the input with it,
// until that register empties. The user writes kappa through cfg_we_i /
// cfg_wdata_i only while idle; the block itself does not enforce this.
module wave_1d_stencil_update import wsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [KAPPA_W-1:0] cfg_wdata_i,
  wsu_in_if.sink             in_if,
  wsu_out_if.source          out_if
);

  wsu_cmd_t cmd;
  logic     in_ready;

  wsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_start_i  (in_if.line_start),
    .in_ready_o  (in_ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  wsu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .old_sample_i   (in_if.old_sample),
    .older_centre_i (in_if.older_centre),
    .line_last_i    (in_if.line_last),
    .new_value_o    (out_if.new_value),
    .last_o         (out_if.last)
  );

  assign in_if.ready = in_ready;

endmodule
